// ===== sv/msmix_pkg.sv =====
// Shared types and constants for the multi-voice sample mixer.
// No dependencies; every other file takes names from here by scope or by import.
package msmix_pkg;

    // Voice count and sample store size
    localparam int VOICE_COUNT = 6;
    localparam int STORE_DEPTH = 16384;

    // Fixed field widths of the item ports
    localparam int MODE_W   = 2;
    localparam int IN_ADDR_W = 14;
    localparam int SAMPLE_W = 8;
    localparam int TAKEN_W  = 3;

    // Derived widths (store depth is a power of two)
    localparam int STORE_AW = $clog2(STORE_DEPTH);
    localparam int VIDX_W   = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int CNT_W    = $clog2(VOICE_COUNT + 1);

    // Item modes
    localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRIGGER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd2;

    // Bias applied per active voice: (b >> 1) - 64, as an 8-bit addend
    localparam logic [SAMPLE_W-1:0] VOICE_BIAS = 8'd192;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Sample store access from the sequencer
    typedef struct packed {
        logic                  we;
        logic [STORE_AW-1:0]   waddr;
        logic [SAMPLE_W-1:0]   wdata;
        logic [STORE_AW-1:0]   raddr;
    } store_req_t;

    // Finished result handed to the output stage
    typedef struct packed {
        logic [SAMPLE_W-1:0] mixed_sample;
        logic                trigger_dropped;
        logic [TAKEN_W-1:0]  voice_taken;
    } result_t;

endpackage

// ===== sv/multi_voice_sample_mixer.sv =====
// Six-voice sample mixer. One item is taken at a time: a load writes the store
// and goes straight to its result, a trigger or tick walks the voices through the
// single store read port that visits one voice per cycle. The result waits in an
// output register; the next item is accepted once the sequencer has passed its
// result on. The store has no reset; address zero always reads as zero.
// Depends on msmix_pkg, msmix_store and msmix_voice_seq.
module multi_voice_sample_mixer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [msmix_pkg::MODE_W-1:0]    s_mode,
    input  logic [msmix_pkg::IN_ADDR_W-1:0] s_address,
    input  logic [msmix_pkg::SAMPLE_W-1:0]  s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [msmix_pkg::SAMPLE_W-1:0]  m_mixed_sample,
    output logic                            m_trigger_dropped,
    output logic [msmix_pkg::TAKEN_W-1:0]   m_voice_taken
);

    msmix_pkg::store_req_t          store_req;
    logic [msmix_pkg::SAMPLE_W-1:0] rd_byte;
    logic                           res_valid;
    logic                           res_ready;
    msmix_pkg::result_t             res;
    logic                           out_valid_reg;
    msmix_pkg::result_t             out_reg;

    msmix_store u_store (
        .aclk    (aclk),
        .req     (store_req),
        .rd_byte (rd_byte)
    );

    msmix_voice_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_mode    (s_mode),
        .in_address (s_address),
        .in_data    (s_data),
        .store_req  (store_req),
        .rd_byte    (rd_byte),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register: load when empty or being drained
    assign res_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_mixed_sample    = out_reg.mixed_sample;
    assign m_trigger_dropped = out_reg.trigger_dropped;
    assign m_voice_taken     = out_reg.voice_taken;

endmodule

// ===== sv/msmix_store.sv =====
// Sample store: single-port-write, registered-read byte memory.
// Depends on msmix_pkg; address zero always reads back as zero.
module msmix_store (
    input  logic                           aclk,
    input  msmix_pkg::store_req_t          req,
    output logic [msmix_pkg::SAMPLE_W-1:0] rd_byte
);

    logic [msmix_pkg::SAMPLE_W-1:0] mem [msmix_pkg::STORE_DEPTH];
    logic [msmix_pkg::SAMPLE_W-1:0] rdata_reg;
    logic                           rd_zero_reg;

    // Write one byte; address zero is never written
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Registered read, remember whether the silent address was asked for
    always_ff @(posedge aclk) begin
        rdata_reg   <= mem[req.raddr];
        rd_zero_reg <= (req.raddr == '0);
    end

    assign rd_byte = rd_zero_reg ? '0 : rdata_reg;

endmodule

// ===== sv/msmix_voice_seq.sv =====
// Voice sequencer: holds voice addresses and walks the voices through one
// shared store read port and one 8-bit accumulator. Depends on msmix_pkg.
module msmix_voice_seq (
    input  logic                            aclk,
    input  logic                            aresetn,
    // item in
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [msmix_pkg::MODE_W-1:0]    in_mode,
    input  logic [msmix_pkg::IN_ADDR_W-1:0] in_address,
    input  logic [msmix_pkg::SAMPLE_W-1:0]  in_data,
    // store port
    output msmix_pkg::store_req_t           store_req,
    input  logic [msmix_pkg::SAMPLE_W-1:0]  rd_byte,
    // result out
    output logic                            res_valid,
    input  logic                            res_ready,
    output msmix_pkg::result_t              res
);

    localparam logic [msmix_pkg::CNT_W-1:0] CNT_LAST =
        msmix_pkg::CNT_W'(msmix_pkg::VOICE_COUNT);
    localparam logic [msmix_pkg::VIDX_W-1:0] IDX_LAST =
        msmix_pkg::VIDX_W'(msmix_pkg::VOICE_COUNT - 1);
    localparam logic [msmix_pkg::STORE_AW-1:0] ADDR_LAST =
        msmix_pkg::STORE_AW'(msmix_pkg::STORE_DEPTH - 1);

    msmix_pkg::state_t state_reg, state_next;

    logic [msmix_pkg::STORE_AW-1:0] voice_addr_reg [msmix_pkg::VOICE_COUNT];
    logic [msmix_pkg::STORE_AW-1:0] voice_addr_next [msmix_pkg::VOICE_COUNT];

    logic [msmix_pkg::MODE_W-1:0]   mode_reg, mode_next;
    logic [msmix_pkg::STORE_AW-1:0] start_reg, start_next;
    logic [msmix_pkg::SAMPLE_W-1:0] acc_reg, acc_next;
    logic                           dropped_reg, dropped_next;
    logic [msmix_pkg::TAKEN_W-1:0]  taken_reg, taken_next;
    logic [msmix_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [msmix_pkg::VIDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic [msmix_pkg::STORE_AW-1:0] pend_addr_reg, pend_addr_next;

    logic                           accept;
    logic                           issue;
    logic                           eval;
    logic                           busy;
    logic                           scan_end;
    logic [msmix_pkg::STORE_AW-1:0] rd_addr;
    logic [msmix_pkg::STORE_AW-1:0] step_addr;

    assign in_ready = (state_reg == msmix_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Read one voice per cycle, judge the one read the cycle before
    assign issue     = (state_reg == msmix_pkg::ST_SCAN) && (cnt_reg < CNT_LAST);
    assign eval      = (state_reg == msmix_pkg::ST_SCAN) && pend_valid_reg;
    assign busy      = (rd_byte != '0);
    assign rd_addr   = voice_addr_reg[cnt_reg[msmix_pkg::VIDX_W-1:0]];
    assign step_addr = (pend_addr_reg == ADDR_LAST) ? '0 : pend_addr_reg + 1'b1;
    assign scan_end  = eval && ((pend_idx_reg == IDX_LAST) ||
                       (mode_reg == msmix_pkg::MODE_TRIGGER && !busy));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            msmix_pkg::ST_IDLE: begin
                if (accept) begin
                    if (in_mode == msmix_pkg::MODE_TRIGGER ||
                        in_mode == msmix_pkg::MODE_TICK) begin
                        state_next = msmix_pkg::ST_SCAN;
                    end else begin
                        state_next = msmix_pkg::ST_DONE;
                    end
                end
            end
            msmix_pkg::ST_SCAN: begin
                if (scan_end) begin
                    state_next = msmix_pkg::ST_DONE;
                end
            end
            msmix_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = msmix_pkg::ST_IDLE;
                end
            end
            default: state_next = msmix_pkg::ST_IDLE;
        endcase
    end

    // Datapath and store port
    always_comb begin
        voice_addr_next = voice_addr_reg;
        mode_next       = mode_reg;
        start_next      = start_reg;
        acc_next        = acc_reg;
        dropped_next    = dropped_reg;
        taken_next      = taken_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = issue;
        pend_idx_next   = cnt_reg[msmix_pkg::VIDX_W-1:0];
        pend_addr_next  = rd_addr;

        store_req.we    = 1'b0;
        store_req.waddr = msmix_pkg::STORE_AW'(in_address);
        store_req.wdata = in_data;
        store_req.raddr = rd_addr;

        if (accept) begin
            // latch the item and clear the result (a tick's mix starts from its data)
            mode_next       = in_mode;
            start_next      = msmix_pkg::STORE_AW'(in_address);
            acc_next        = (in_mode == msmix_pkg::MODE_TICK) ? in_data : '0;
            dropped_next    = 1'b0;
            taken_next      = '0;
            cnt_next        = '0;
            pend_valid_next = 1'b0;
            if (in_mode == msmix_pkg::MODE_LOAD &&
                msmix_pkg::STORE_AW'(in_address) != '0) begin
                store_req.we = 1'b1;
            end
        end

        if (issue) begin
            cnt_next = cnt_reg + 1'b1;
        end

        if (eval) begin
            case (mode_reg)
                msmix_pkg::MODE_TRIGGER: begin
                    // hand the clip to the first silent voice
                    if (!busy) begin
                        voice_addr_next[pend_idx_reg] = start_reg;
                        taken_next = msmix_pkg::TAKEN_W'(pend_idx_reg);
                    end else if (pend_idx_reg == IDX_LAST) begin
                        dropped_next = 1'b1;
                    end
                end
                msmix_pkg::MODE_TICK: begin
                    // mix in an active voice and advance it
                    if (busy) begin
                        acc_next = acc_reg + {1'b0, rd_byte[msmix_pkg::SAMPLE_W-1:1]}
                                   + msmix_pkg::VOICE_BIAS;
                        voice_addr_next[pend_idx_reg] = step_addr;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= msmix_pkg::ST_IDLE;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
            for (int i = 0; i < msmix_pkg::VOICE_COUNT; i++) begin
                voice_addr_reg[i] <= '0;
            end
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            voice_addr_reg <= voice_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg      <= mode_next;
        start_reg     <= start_next;
        acc_reg       <= acc_next;
        dropped_reg   <= dropped_next;
        taken_reg     <= taken_next;
        pend_idx_reg  <= pend_idx_next;
        pend_addr_reg <= pend_addr_next;
    end

    // Result outputs
    always_comb begin
        res_valid           = (state_reg == msmix_pkg::ST_DONE);
        res.mixed_sample    = acc_reg;
        res.trigger_dropped = dropped_reg;
        res.voice_taken     = taken_reg;
    end

endmodule

// ===== tb/tb_multi_voice_sample_mixer.sv =====
// Self-checking testbench for multi_voice_sample_mixer: directed rows, then random clip loads,
// triggers and ticks, checked against an in-bench predictor of voices and sample store.
// Depends on msmix_pkg and the mixer RTL; needs no files or arguments.
`timescale 1ns / 100ps

module tb_multi_voice_sample_mixer;
    import msmix_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int RAND_ITEMS   = 1800;
    localparam int HOLD_AT      = 1500;     // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 20;       // well past the worst-case latency
    localparam int TIMEOUT_NS   = 6_000_000;

    // One directed row: item fields, then a typed expectation where `typed` is set
    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [IN_ADDR_W-1:0] addr;
        logic [SAMPLE_W-1:0]  data;
        logic                 typed;
        logic [SAMPLE_W-1:0]  w_mixed;
        logic                 w_drop;
        logic [TAKEN_W-1:0]   w_taken;
    } dir_row_t;

    localparam int DIR_N = 23;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // unused mode right after reset: no effect, all zero
        '{MODE_UNUSED,  14'h3FFF, 8'hFF, 1'b1, 8'h00, 1'b0, 3'd0},
        // tick with every voice parked on silence passes the base through
        '{MODE_TICK,    14'h0000, 8'hA5, 1'b1, 8'hA5, 1'b0, 3'd0},
        // trigger at a zero byte: voice 0 takes it but stays idle
        '{MODE_TRIGGER, 14'h0000, 8'h00, 1'b1, 8'h00, 1'b0, 3'd0},
        // load to address zero is ignored
        '{MODE_LOAD,    14'h0000, 8'hFF, 1'b1, 8'h00, 1'b0, 3'd0},
        '{MODE_TICK,    14'h0000, 8'hFF, 1'b1, 8'hFF, 1'b0, 3'd0},
        // clip at the top of the store, written back to front
        '{MODE_LOAD,    14'h3FFF, 8'hFF, 1'b1, 8'h00, 1'b0, 3'd0},
        '{MODE_LOAD,    14'h3FFE, 8'h01, 1'b1, 8'h00, 1'b0, 3'd0},
        '{MODE_LOAD,    14'h3FFD, 8'h80, 1'b1, 8'h00, 1'b0, 3'd0},
        // fill all six voices in order
        '{MODE_TRIGGER, 14'h3FFD, 8'h00, 1'b1, 8'h00, 1'b0, 3'd0},
        '{MODE_TRIGGER, 14'h3FFD, 8'h00, 1'b1, 8'h00, 1'b0, 3'd1},
        '{MODE_TRIGGER, 14'h3FFD, 8'h00, 1'b1, 8'h00, 1'b0, 3'd2},
        '{MODE_TRIGGER, 14'h3FFD, 8'h00, 1'b1, 8'h00, 1'b0, 3'd3},
        '{MODE_TRIGGER, 14'h3FFD, 8'h00, 1'b1, 8'h00, 1'b0, 3'd4},
        '{MODE_TRIGGER, 14'h3FFD, 8'h00, 1'b1, 8'h00, 1'b0, 3'd5},
        // no idle voice left: drop
        '{MODE_TRIGGER, 14'h3FFD, 8'h00, 1'b1, 8'h00, 1'b1, 3'd0},
        '{MODE_TRIGGER, 14'h0000, 8'hFF, 1'b1, 8'h00, 1'b1, 3'd0},
        // six voices through mid, lowest and highest bytes, then past the store end
        '{MODE_TICK,    14'h0000, 8'h00, 1'b0, 8'h00, 1'b0, 3'd0},
        '{MODE_TICK,    14'h2AAA, 8'h10, 1'b0, 8'h00, 1'b0, 3'd0},
        '{MODE_TICK,    14'h1555, 8'hFF, 1'b0, 8'h00, 1'b0, 3'd0},
        '{MODE_TICK,    14'h3FFF, 8'h5A, 1'b0, 8'h00, 1'b0, 3'd0},
        '{MODE_TRIGGER, 14'h3FFF, 8'h00, 1'b1, 8'h00, 1'b0, 3'd0},
        '{MODE_UNUSED,  14'h1555, 8'h2A, 1'b1, 8'h00, 1'b0, 3'd0},
        '{MODE_TICK,    14'h0000, 8'h80, 1'b0, 8'h00, 1'b0, 3'd0}
    };

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [MODE_W-1:0]    s_mode    = MODE_LOAD;
    logic [IN_ADDR_W-1:0] s_address = '0;
    logic [SAMPLE_W-1:0]  s_data    = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [SAMPLE_W-1:0]  m_mixed_sample;
    logic                 m_trigger_dropped;
    logic [TAKEN_W-1:0]   m_voice_taken;

    // Predictor state: voice pointers, store image and which entries hold data
    logic [IN_ADDR_W-1:0] voice_ptr [VOICE_COUNT];
    logic [SAMPLE_W-1:0]  clip_mem [STORE_DEPTH];
    bit                   clip_mem_set [STORE_DEPTH];

    result_t              mix_results_due [$];
    logic [IN_ADDR_W-1:0] clip_starts [$];

    int snd_idle_pct = 8;
    int rcv_idle_pct = 84;
    int mix_items;
    int results_seen;
    int mismatch_count;
    int hold_left;
    bit hold_done;
    int n_load, n_trig, n_drop, n_tick, n_unused;

    multi_voice_sample_mixer i_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_address         (s_address),
        .s_data            (s_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_mixed_sample    (m_mixed_sample),
        .m_trigger_dropped (m_trigger_dropped),
        .m_voice_taken     (m_voice_taken)
    );

    always #6 aclk = ~aclk;

    // Address zero always reads as silence
    function automatic logic [SAMPLE_W-1:0] store_byte(input logic [IN_ADDR_W-1:0] a);
        return (a == '0) ? '0 : clip_mem[a];
    endfunction

    // Apply one item to the predictor state and return the result it causes
    function automatic result_t compute_mix_result(input logic [MODE_W-1:0] mode,
                                                   input logic [IN_ADDR_W-1:0] addr,
                                                   input logic [SAMPLE_W-1:0] data);
        result_t             r;
        logic [SAMPLE_W-1:0] b;
        bit                  found;
        r = '0;
        found = 1'b0;
        case (mode)
            MODE_LOAD: begin
                if (addr != '0) begin
                    clip_mem[addr] = data;
                    clip_mem_set[addr] = 1'b1;
                end
            end
            MODE_TRIGGER: begin
                // lowest idle voice takes the clip
                for (int v = 0; v < VOICE_COUNT; v++) begin
                    if (!found && store_byte(voice_ptr[v]) == '0) begin
                        found = 1'b1;
                        voice_ptr[v] = addr;
                        r.voice_taken = TAKEN_W'(v);
                    end
                end
                r.trigger_dropped = !found;
            end
            MODE_TICK: begin
                // each active voice adds (byte >> 1) - 64 and steps on
                r.mixed_sample = data;
                for (int v = 0; v < VOICE_COUNT; v++) begin
                    b = store_byte(voice_ptr[v]);
                    if (b != '0) begin
                        r.mixed_sample = r.mixed_sample + (b >> 1) - 8'd64;
                        voice_ptr[v] = voice_ptr[v] + 1'b1;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offer one item, hold it until accepted, then queue its expected result
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [IN_ADDR_W-1:0] addr,
                             input logic [SAMPLE_W-1:0] data, input bit typed,
                             input result_t want);
        result_t pred;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= mode;
        s_address <= addr;
        s_data    <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = compute_mix_result(mode, addr, data);
        mix_results_due.push_back(typed ? want : pred);
        case (mode)
            MODE_LOAD:    n_load++;
            MODE_TRIGGER: begin
                n_trig++;
                if (pred.trigger_dropped) n_drop++;
            end
            MODE_TICK:    n_tick++;
            default:      n_unused++;
        endcase
        if (mode != MODE_UNUSED && !(mode == MODE_LOAD && addr == '0)) mix_items++;
    endtask

    // Random part: clip writes, triggers onto written clips, tick bursts, some noise
    task automatic run_random_items();
        int                   kind, len, n;
        logic [IN_ADDR_W-1:0] s, a, nxt;
        logic [SAMPLE_W-1:0]  d;
        while (mix_items < RAND_ITEMS) begin
            if (mix_items < RAND_ITEMS / 3) begin
                snd_idle_pct = 8;
                rcv_idle_pct = 84;
            end else if (mix_items < 2 * RAND_ITEMS / 3) begin
                snd_idle_pct = 84;
                rcv_idle_pct = 8;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                // write a clip back to front so every nonzero byte has a written successor
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40)
                                                  : $urandom_range(1, 10);
                n = $urandom_range(0, 9);
                if (n < 5)      s = IN_ADDR_W'($urandom_range(1, 511));
                else if (n < 9) s = IN_ADDR_W'($urandom_range(1, STORE_DEPTH - 1));
                else            s = IN_ADDR_W'(STORE_DEPTH - $urandom_range(1, len + 1));
                for (int i = len; i >= 0; i--) begin
                    a = s + IN_ADDR_W'(i);
                    d = (i == len) ? '0 : SAMPLE_W'($urandom_range(1, 255));
                    send_item(MODE_LOAD, a, d, 1'b0, '0);
                end
                clip_starts.push_back(s);
                if (clip_starts.size() > 32) void'(clip_starts.pop_front());
            end else if (kind < 40) begin
                n = $urandom_range(1, 4);
                repeat (n) begin
                    a = (clip_starts.size() == 0) ? '0
                        : clip_starts[$urandom_range(0, clip_starts.size() - 1)];
                    send_item(MODE_TRIGGER, a, SAMPLE_W'($urandom), 1'b0, '0);
                end
            end else if (kind < 85) begin
                n = $urandom_range(1, 16);
                repeat (n) send_item(MODE_TICK, IN_ADDR_W'($urandom), SAMPLE_W'($urandom),
                                     1'b0, '0);
            end else begin
                // noise: stray loads, triggers anywhere already written, unused mode
                a = IN_ADDR_W'($urandom);
                d = SAMPLE_W'($urandom);
                nxt = a + 1'b1;
                case ($urandom_range(0, 3))
                    0: send_item(MODE_UNUSED, a, d, 1'b0, '0);
                    1: begin
                        // keep the byte zero where its successor was never written
                        if (a != '0 && nxt != '0 && !clip_mem_set[nxt]) d = '0;
                        send_item(MODE_LOAD, a, d, 1'b0, '0);
                    end
                    2: begin
                        if (a != '0 && !clip_mem_set[a]) a = '0;
                        send_item(MODE_TRIGGER, a, d, 1'b0, '0);
                    end
                    default: send_item(MODE_LOAD, '0, d, 1'b0, '0);
                endcase
            end
        end
    endtask

    task automatic check_field(input string field, input logic [SAMPLE_W-1:0] want,
                               input logic [SAMPLE_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h, actual %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Result side: check each accepted item, drive ready with random stalls and one long hold
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (mix_results_due.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual %h/%b/%0d", $time,
                         m_mixed_sample, m_trigger_dropped, m_voice_taken);
                mismatch_count++;
            end else begin
                want = mix_results_due.pop_front();
                check_field("mixed_sample", want.mixed_sample, m_mixed_sample);
                check_field("trigger_dropped", SAMPLE_W'(want.trigger_dropped),
                            SAMPLE_W'(m_trigger_dropped));
                check_field("voice_taken", SAMPLE_W'(want.voice_taken),
                            SAMPLE_W'(m_voice_taken));
            end
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // Main sequence: reset, directed rows, random items, drain and verdict
    initial begin
        int drain;
        for (int v = 0; v < VOICE_COUNT; v++) voice_ptr[v] = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_N; i++) begin
            send_item(DIR_ROWS[i].mode, DIR_ROWS[i].addr, DIR_ROWS[i].data, DIR_ROWS[i].typed,
                      '{DIR_ROWS[i].w_mixed, DIR_ROWS[i].w_drop, DIR_ROWS[i].w_taken});
        end
        mix_items = 0;
        run_random_items();
        s_valid <= 1'b0;

        drain = 0;
        while (mix_results_due.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mix_results_due.size() != 0) begin
            $display("%0t ns: %0d results never arrived", $time, mix_results_due.size());
            mismatch_count += mix_results_due.size();
        end

        $display("Checked %0d results: %0d loads, %0d triggers (%0d dropped), %0d ticks,",
                 results_seen, n_load, n_trig, n_drop, n_tick);
        $display("%0d unused-mode items, with both stall patterns and a %0d-cycle output hold",
                 n_unused, HOLD_CYCLES);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("%0t ns: timed out with %0d results pending", $time, mix_results_due.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/msmix_pkg.sv
sv/msmix_store.sv
sv/msmix_voice_seq.sv
sv/multi_voice_sample_mixer.sv
tb/tb_multi_voice_sample_mixer.sv
